@@ hw/rtl/cpww_pkg.sv @@
// shared types and constants for the code page write watch
package cpww_pkg;

	localparam int ADDR_W = 32;
	localparam int PAGE_W = 16;
	localparam int OP_W   = 2;
	// page walk counter, wide enough for a full sweep of 65536 pages
	localparam int WALK_W = 17;
	localparam int IN_W   = 96;
	localparam int OUT_W  = 24;

	typedef enum logic [OP_W-1:0] {
		OP_MARK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FLUSH = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MARK,
		S_TAIL,
		S_WRITE,
		S_FLUSH,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic walk_step;
		logic tail_write;
		logic write_resolve;
		logic flush_emit;
		logic flush_ovf;
		logic flush_none;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic walk_done;
		logic list_empty;
		logic ovf_flag;
		logic emit_last;
		logic out_free;
	} status_t;

endpackage

@@ hw/rtl/cpww_ctrl.sv @@
// controller state machine for the code page write watch
module cpww_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  cpww_pkg::status_t sts,
	output cpww_pkg::cmd_t    cmd
);
	import cpww_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.walk_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					unique case (sts.op)
						OP_MARK:  state_d = S_MARK;
						OP_WRITE: state_d = S_WRITE;
						OP_FLUSH: state_d = S_FLUSH;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_MARK: begin
				if (sts.walk_done) state_d = S_TAIL;
			end
			S_TAIL: state_d = S_IDLE;
			S_WRITE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					if (sts.ovf_flag) state_d = S_CLEAR;
					else if (sts.list_empty) state_d = S_IDLE;
					else state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free && sts.emit_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_CLEAR: cmd.walk_step = !sts.walk_done;
			S_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			S_MARK: cmd.walk_step = !sts.walk_done;
			S_TAIL: cmd.tail_write = 1'b1;
			S_WRITE: cmd.write_resolve = sts.out_free;
			S_FLUSH: begin
				// overflow wins over queued pages: one full reset result, then sweep
				if (sts.out_free) begin
					if (sts.ovf_flag) cmd.flush_ovf = 1'b1;
					else if (sts.list_empty) cmd.flush_none = 1'b1;
				end
			end
			S_EMIT: cmd.flush_emit = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

@@ hw/rtl/cpww_dpath.sv @@
// datapath: page map memory, dirty list, walk counters and result register
module cpww_dpath #(
	parameter int DIRTY_DEPTH = 16,
	parameter int NUM_PAGES   = 65536
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cpww_pkg::cmd_t               cmd,
	input  logic [cpww_pkg::IN_W-1:0]    s_tdata,   // range_start, range_end, write_address
	input  logic [cpww_pkg::OP_W-1:0]    s_tuser,   // opcode
	input  logic                        m_tready,
	output cpww_pkg::status_t            sts,
	output logic                        m_tvalid,
	output logic [cpww_pkg::OUT_W-1:0]   m_tdata,   // code_hit, list_overflow, dirty_page[15:0], invalidated
	output logic                        m_tuser,   // page_valid
	output logic                        m_tlast    // last_result
);
	import cpww_pkg::*;

	localparam int IW  = $clog2(NUM_PAGES);
	localparam int CNW = $clog2(DIRTY_DEPTH + 1);
	localparam int LW  = (DIRTY_DEPTH > 1) ? $clog2(DIRTY_DEPTH) : 1;
	localparam logic [WALK_W-1:0] PAGES_C = WALK_W'(NUM_PAGES);

	// input fields
	logic [OP_W-1:0]   in_op;
	logic [ADDR_W-1:0] in_start, in_end, in_addr;
	logic [PAGE_W-1:0] in_page;

	assign in_op    = s_tuser;
	assign in_start = s_tdata[31:0];
	assign in_end   = s_tdata[63:32];
	assign in_addr  = s_tdata[95:64];
	assign in_page  = in_addr[23:8];

	// range setup for a mark request
	logic [ADDR_W:0]   diff;
	logic [ADDR_W-1:0] end_m1;
	logic [24:0]       steps;
	logic              range_gt, range_huge;
	logic [PAGE_W-1:0] tail_page;

	always_comb begin
		diff       = {1'b0, in_end} - {1'b0, in_start};
		range_gt   = !diff[ADDR_W] && (diff[ADDR_W-1:0] != '0);
		steps      = {1'b0, diff[31:8]} + 25'(|diff[7:0]);
		range_huge = range_gt && (steps[24:16] != '0);
		end_m1     = in_end - 32'd1;
		tail_page  = (in_end == '0) ? '0 : end_m1[23:8];
	end

	// walk counters
	logic [PAGE_W-1:0] pg_q, tail_q;
	logic [WALK_W-1:0] rem_q;
	logic              wbit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_q   <= '0;
			rem_q  <= PAGES_C;
			wbit_q <= 1'b0;
		end else if (cmd.accept && in_op == OP_MARK) begin
			wbit_q <= 1'b1;
			if (range_huge) begin
				pg_q  <= '0;
				rem_q <= PAGES_C;
			end else if (range_gt) begin
				pg_q  <= in_start[23:8];
				rem_q <= {1'b0, steps[15:0]};
			end else begin
				rem_q <= '0;
			end
		end else if (cmd.flush_ovf) begin
			pg_q   <= '0;
			rem_q  <= PAGES_C;
			wbit_q <= 1'b0;
		end else if (cmd.walk_step) begin
			pg_q  <= pg_q + 16'd1;
			rem_q <= rem_q - 17'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) tail_q <= tail_page;
	end

	// page map memory
	logic              map_mem [NUM_PAGES];
	logic              map_rd_q, inmap_q;
	logic [PAGE_W-1:0] page_q;
	logic              wr_en, wr_bit, pg_in, tail_in;
	logic [IW-1:0]     wr_idx;

	always_comb begin
		pg_in   = {1'b0, pg_q} < PAGES_C;
		tail_in = {1'b0, tail_q} < PAGES_C;
		wr_en   = (cmd.walk_step && (rem_q != '0) && pg_in) || (cmd.tail_write && tail_in);
		wr_idx  = cmd.tail_write ? tail_q[IW-1:0] : pg_q[IW-1:0];
		wr_bit  = cmd.tail_write ? 1'b1 : wbit_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) map_mem[wr_idx] <= wr_bit;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			map_rd_q <= map_mem[in_page[IW-1:0]];
			inmap_q  <= {1'b0, in_page} < PAGES_C;
			page_q   <= in_page;
		end
	end

	// dirty list
	logic [PAGE_W-1:0]      list_q [DIRTY_DEPTH];
	logic [CNW-1:0]         count_q, idx_q;
	logic                   ovf_q;
	logic [DIRTY_DEPTH-1:0] match;
	logic                   wr_hit, dup, full, emit_last;

	always_comb begin
		for (int i = 0; i < DIRTY_DEPTH; i++) begin
			match[i] = (CNW'(i) < count_q) && (list_q[i] == page_q);
		end
		wr_hit    = map_rd_q && inmap_q;
		dup       = |match;
		full      = count_q == CNW'(DIRTY_DEPTH);
		emit_last = (idx_q + 1'b1) == count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.write_resolve && wr_hit && !dup) begin
			if (full) ovf_q <= 1'b1;
			else count_q <= count_q + 1'b1;
		end else if (cmd.flush_ovf) begin
			count_q <= '0;
			idx_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.flush_emit) begin
			if (emit_last) begin
				count_q <= '0;
				idx_q   <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_resolve && wr_hit && !dup && !full) list_q[count_q[LW-1:0]] <= page_q;
	end

	// result register
	logic              out_valid_q, out_free, res_load;
	logic              o_hit_q, o_ovf_q, o_pv_q, o_inv_q, o_last_q;
	logic [PAGE_W-1:0] o_page_q;
	logic              r_hit, r_ovf, r_pv, r_inv, r_last;
	logic [PAGE_W-1:0] r_page;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		res_load = cmd.write_resolve || cmd.flush_none || cmd.flush_ovf || cmd.flush_emit;
		r_hit    = 1'b0;
		r_ovf    = 1'b0;
		r_pv     = 1'b0;
		r_page   = '0;
		r_inv    = 1'b0;
		r_last   = 1'b1;
		if (cmd.write_resolve) begin
			r_hit = wr_hit;
			r_ovf = wr_hit && !dup && full;
		end else if (cmd.flush_ovf) begin
			r_ovf = 1'b1;
			r_inv = 1'b1;
		end else if (cmd.flush_emit) begin
			r_pv   = 1'b1;
			r_page = list_q[idx_q[LW-1:0]];
			r_inv  = 1'b1;
			r_last = emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			o_hit_q  <= r_hit;
			o_ovf_q  <= r_ovf;
			o_pv_q   <= r_pv;
			o_page_q <= r_page;
			o_inv_q  <= r_inv;
			o_last_q <= r_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, o_inv_q, o_page_q, o_ovf_q, o_hit_q};
	assign m_tuser  = o_pv_q;
	assign m_tlast  = o_last_q;

	always_comb begin
		sts.op         = op_t'(in_op);
		sts.walk_done  = rem_q == '0;
		sts.list_empty = count_q == '0;
		sts.ovf_flag   = ovf_q;
		sts.emit_last  = emit_last;
		sts.out_free   = out_free;
	end

endmodule

@@ hw/rtl/code_page_write_watch.sv @@
// top level of the code page write watch: controller plus datapath
//
//  channel  dir  signals                      contents
//  s_*      in   tvalid tready tdata[95:0]    range_start, range_end, write_address
//                tuser[1:0]                   opcode
//  m_*      out  tvalid tready tdata[23:0]    code_hit, list_overflow, dirty_page, invalidated
//                tuser tlast                  page_valid, last_result
//
// guest write: a registered page map read, then the parallel dirty list compare.
// mark: one map write per page in the page walk (a huge range sweeps NUM_PAGES
// pages). flush: one result per queued page; after an overflow, a map clearing
// sweep of NUM_PAGES pages.
// after reset a map clearing sweep of NUM_PAGES pages runs with s_tready low.
// a result waits in the output register; a stalled m_tready holds the controller.
module code_page_write_watch #(
	parameter int DIRTY_DEPTH = 16,
	parameter int NUM_PAGES   = 65536
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [cpww_pkg::IN_W-1:0]  s_tdata,   // range_start, range_end, write_address
	input  logic [cpww_pkg::OP_W-1:0]  s_tuser,   // opcode
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [cpww_pkg::OUT_W-1:0] m_tdata,   // code_hit, list_overflow, dirty_page[15:0], invalidated
	output logic                      m_tuser,   // page_valid
	output logic                      m_tlast    // last_result
);
	import cpww_pkg::*;

	cmd_t    cmd;
	status_t sts;

	cpww_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cpww_dpath #(
		.DIRTY_DEPTH (DIRTY_DEPTH),
		.NUM_PAGES   (NUM_PAGES)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ hw/rtl/cpww_checker.sv @@
// port checker for the code page write watch, bound to the top level
module cpww_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [cpww_pkg::OUT_W-1:0] m_tdata,
	input logic                      m_tuser,
	input logic                      m_tlast
);
	import cpww_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// a flushed page is always an invalidation and never a write hit
	a_page_inv: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[18] && !m_tdata[0] && !m_tdata[1])
		else $error("flushed page without invalidate");

	// page field is zero unless a flushed page is shown
	a_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[17:2] == '0)
		else $error("page field set without page_valid");

	// overflow is reported only on the single result of its request
	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tlast && (m_tdata[0] != m_tdata[18]))
		else $error("overflow result malformed");

endmodule

bind code_page_write_watch cpww_checker u_cpww_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
